@@ sv/arh_pkg.sv @@
package arh_pkg;

  localparam int BIN_COUNT_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int SAMPLE_W       = 32;
  localparam int START_W        = 31;
  localparam int EXP_W          = 5;

  localparam logic [EXP_W-1:0] EXP_LIMIT = 5'd31;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic capture;      // take a new word into the sample register
    logic widen;        // double the bin width by one step
    logic emit_sample;  // count the sample and load the output register
    logic emit_neg;     // load the output register with a dropped sample
    logic emit_read;    // load the output register with the next bin
  } arh_cmd_t;

  typedef struct packed {
    logic neg;
    logic need_widen;
    logic rd_last;
  } arh_status_t;

endpackage

@@ sv/arh_datapath.sv @@
module arh_datapath #(
  parameter int BIN_COUNT  = arh_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = arh_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  arh_pkg::arh_cmd_t                cmd_i,
  output arh_pkg::arh_status_t             status_o,
  input  logic [arh_pkg::SAMPLE_W-1:0]     sample_i,
  output logic [$clog2(BIN_COUNT)-1:0]     bin_num_o,
  output logic [COUNT_BITS-1:0]            bin_count_o,
  output logic [arh_pkg::START_W-1:0]      bin_start_o,
  output logic [arh_pkg::EXP_W-1:0]        scale_log2_o,
  output logic                             ignored_o,
  output logic                             last_o
);
  import arh_pkg::*;

  localparam int IdxW = $clog2(BIN_COUNT);
  localparam int Half = BIN_COUNT / 2;

  logic [SAMPLE_W-1:0]   sample_q;
  logic [EXP_W-1:0]      exp_q, exp_d;
  logic [IdxW-1:0]       rd_idx_q;
  logic [COUNT_BITS-1:0] bins_q [BIN_COUNT];
  logic [COUNT_BITS-1:0] bins_d [BIN_COUNT];
  logic [COUNT_BITS-1:0] merged [BIN_COUNT];

  logic [START_W-1:0]    raw;
  logic [START_W-1:0]    shifted;
  logic                  over;
  logic [IdxW-1:0]       idx_sel;
  logic [IdxW-1:0]       sel;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic [START_W-1:0]    start;

  logic [IdxW-1:0]       bin_num_q;
  logic [COUNT_BITS-1:0] bin_count_q;
  logic [START_W-1:0]    bin_start_q;
  logic [EXP_W-1:0]      scale_q;
  logic                  ignored_q;
  logic                  last_q;

  assign raw     = sample_q[START_W-1:0];
  assign shifted = raw >> exp_q;
  assign over    = (shifted >= START_W'(BIN_COUNT));
  assign idx_sel = over ? IdxW'(BIN_COUNT - 1) : shifted[IdxW-1:0];

  assign status_o.neg        = sample_q[SAMPLE_W-1];
  assign status_o.need_widen = over && (exp_q != EXP_LIMIT);
  assign status_o.rd_last    = (rd_idx_q == IdxW'(BIN_COUNT - 1));

  // one read port, shared by counting and readout
  assign sel   = cmd_i.emit_read ? rd_idx_q : idx_sel;
  assign cur   = bins_q[sel];
  assign inc   = (cur == '1) ? cur : cur + 1'b1;
  assign start = START_W'(sel) << exp_q;

  // pair merge, saturating; an odd top bin has no partner and is dropped
  always_comb begin
    for (int i = 0; i < BIN_COUNT; i++) begin
      merged[i] = '0;
    end
    for (int i = 0; i < Half; i++) begin
      logic [COUNT_BITS:0] sum;
      sum       = {1'b0, bins_q[2*i]} + {1'b0, bins_q[2*i+1]};
      merged[i] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    exp_d = exp_q;
    for (int i = 0; i < BIN_COUNT; i++) begin
      bins_d[i] = bins_q[i];
    end
    if (cmd_i.widen) begin
      exp_d = exp_q + 1'b1;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bins_d[i] = merged[i];
      end
    end else if (cmd_i.emit_sample) begin
      bins_d[idx_sel] = inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bins_q[i] <= '0;
      end
    end else begin
      exp_q <= exp_d;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bins_q[i] <= bins_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.capture) begin
      rd_idx_q <= '0;
    end else if (cmd_i.emit_read) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_neg) begin
      bin_num_q   <= '0;
      bin_count_q <= '0;
      bin_start_q <= '0;
      scale_q     <= exp_q;
      ignored_q   <= 1'b1;
      last_q      <= 1'b1;
    end else if (cmd_i.emit_sample) begin
      bin_num_q   <= idx_sel;
      bin_count_q <= inc;
      bin_start_q <= start;
      scale_q     <= exp_q;
      ignored_q   <= 1'b0;
      last_q      <= 1'b1;
    end else if (cmd_i.emit_read) begin
      bin_num_q   <= rd_idx_q;
      bin_count_q <= cur;
      bin_start_q <= start;
      scale_q     <= exp_q;
      ignored_q   <= 1'b0;
      last_q      <= status_o.rd_last;
    end
  end

  assign bin_num_o    = bin_num_q;
  assign bin_count_o  = bin_count_q;
  assign bin_start_o  = bin_start_q;
  assign scale_log2_o = scale_q;
  assign ignored_o    = ignored_q;
  assign last_o       = last_q;

  a_widen_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.widen |-> exp_q != EXP_LIMIT)
    else $error("widening at exponent limit");

  a_widen_steps_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.widen |=> exp_q == EXP_W'($past(exp_q) + 1'b1))
    else $error("exponent did not step on widening");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_sample |-> !status_o.need_widen && !status_o.neg)
    else $error("sample counted before scaling finished");

endmodule

@@ sv/arh_ctrl.sv @@
module arh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output arh_pkg::arh_cmd_t    cmd_o,
  input  arh_pkg::arh_status_t status_i
);
  import arh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCALE = 3'b010,
    S_READ  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_acc;
  logic   emit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.capture = 1'b1;
          state_d       = (mode_i == MODE_READ) ? S_READ : S_SCALE;
        end
      end
      S_SCALE: begin
        if (status_i.neg) begin
          if (out_free) begin
            cmd_o.emit_neg = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (status_i.need_widen) begin
          cmd_o.widen = 1'b1;
        end else if (out_free) begin
          cmd_o.emit_sample = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.emit_read = 1'b1;
          if (status_i.rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign emit = cmd_o.emit_neg || cmd_o.emit_sample || cmd_o.emit_read;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_i == MODE_READ |=> state_q == S_READ)
    else $error("readout word not started");

  a_read_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ && cmd_o.emit_read && status_i.rd_last |=> state_q == S_IDLE)
    else $error("readout ran past last bin");

  a_no_widen_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE && status_i.neg |-> !cmd_o.widen)
    else $error("dropped sample caused widening");

endmodule

@@ sv/auto_rescaling_histogram.sv @@
// channel | handshake                | payload
// --------+--------------------------+---------------------------------------
// in      | in_valid_i, in_stall_o   | mode_i, sample_i
// out     | out_valid_o, out_stall_i | bin_num_o, bin_count_o, bin_start_o,
//         |                          | scale_log2_o, ignored_o, last_o
//
// a sample word is captured, then the bin width is doubled as needed, as the merge unit
// doubles the width once a cycle, then the sample is counted; a readout word sends
// one bin a cycle through the single bin read port while the output is not stalled.
// reset clears all bins, the width exponent and the output valid at once.
// a stalled output word holds; a new input word is taken while it waits.
module auto_rescaling_histogram #(
  parameter int BIN_COUNT  = arh_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = arh_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [arh_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [$clog2(BIN_COUNT)-1:0] bin_num_o,
  output logic [COUNT_BITS-1:0]        bin_count_o,
  output logic [arh_pkg::START_W-1:0]  bin_start_o,
  output logic [arh_pkg::EXP_W-1:0]    scale_log2_o,
  output logic                         ignored_o,
  output logic                         last_o
);
  import arh_pkg::*;

  arh_cmd_t    cmd;
  arh_status_t status;

  arh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  arh_datapath #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (sample_i),
    .bin_num_o    (bin_num_o),
    .bin_count_o  (bin_count_o),
    .bin_start_o  (bin_start_o),
    .scale_log2_o (scale_log2_o),
    .ignored_o    (ignored_o),
    .last_o       (last_o)
  );

endmodule
